/* rtl/core/tsc_pkg.sv */
// Shared constants, types and functions for the scratchpad check and conversion block.
`timescale 1ns / 1ps
`default_nettype none

package tsc_pkg;

  localparam int unsigned PAD_BYTES = 9;
  localparam int unsigned POS_W     = 4;

  localparam logic [POS_W-1:0] POS_TEMP_LSB = POS_W'(0);
  localparam logic [POS_W-1:0] POS_TEMP_MSB = POS_W'(1);
  localparam logic [POS_W-1:0] POS_CONFIG   = POS_W'(4);
  localparam logic [POS_W-1:0] POS_COUNT    = POS_W'(6);
  localparam logic [POS_W-1:0] POS_LAST     = POS_W'(PAD_BYTES - 1);

  localparam logic [7:0] FAMILY_LEGACY  = 8'd16;
  localparam logic [7:0] FAMILY_RESMASK = 8'd40;
  localparam logic [7:0] FAMILY_RESET   = FAMILY_RESMASK;
  localparam logic [7:0] CRC_POLY       = 8'h8C;

  // Legacy compensation is (16 - count_remain) - 4, folded into one constant.
  localparam logic [15:0] LEGACY_COMP_BASE = 16'd12;

  localparam logic [6:0] HUND_BIT3 = 7'd50;
  localparam logic [6:0] HUND_BIT2 = 7'd25;
  localparam logic [6:0] HUND_BIT1 = 7'd13;
  localparam logic [6:0] HUND_BIT0 = 7'd6;

  // What the frame tracker hands to the result stage.
  typedef struct packed {
    logic        at_last;
    logic        done;
    logic [7:0]  crc;
    logic [15:0] raw;
    logic [7:0]  cfg;
    logic [7:0]  count_remain;
  } frame_t;

  // Byte-wide update of the reflected CRC-8, LSB first.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc_in,
                                             input logic [7:0] data);
    logic [7:0] c;
    logic [7:0] d;
    logic       mix;
    c = crc_in;
    d = data;
    for (int k = 0; k < 8; k++) begin
      mix = c[0] ^ d[0];
      c   = {1'b0, c[7:1]};
      if (mix) begin
        c = c ^ CRC_POLY;
      end
      d = {1'b0, d[7:1]};
    end
    return c;
  endfunction

  function automatic logic [6:0] frac_to_hundredths(input logic [3:0] frac);
    logic [6:0] h;
    h = 7'd0;
    if (frac[3]) h = h + HUND_BIT3;
    if (frac[2]) h = h + HUND_BIT2;
    if (frac[1]) h = h + HUND_BIT1;
    if (frac[0]) h = h + HUND_BIT0;
    return h;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/tsc_frame.sv */
// Frame tracker: byte position, running CRC and the kept scratchpad bytes.
`timescale 1ns / 1ps
`default_nettype none

module tsc_frame (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           accept,
  input  wire logic [7:0]     data_byte,
  output tsc_pkg::frame_t     frame
);
  import tsc_pkg::*;

  logic [POS_W-1:0] byte_position;
  logic [7:0]       crc_running;
  logic [7:0]       kept_bytes [4];
  logic [7:0]       crc_next;
  logic             at_last;

  assign crc_next = crc8_update(crc_running, data_byte);
  // An out-of-range position behaves as the last byte of the frame.
  assign at_last  = (byte_position >= POS_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      crc_running   <= '0;
      for (int i = 0; i < 4; i++) begin
        kept_bytes[i] <= '0;
      end
    end else if (accept) begin
      if (at_last) begin
        byte_position <= '0;
        crc_running   <= '0;
      end else begin
        byte_position <= byte_position + POS_W'(1);
        crc_running   <= crc_next;
      end
      if (byte_position == POS_TEMP_LSB) kept_bytes[0] <= data_byte;
      if (byte_position == POS_TEMP_MSB) kept_bytes[1] <= data_byte;
      if (byte_position == POS_CONFIG)   kept_bytes[2] <= data_byte;
      if (byte_position == POS_COUNT)    kept_bytes[3] <= data_byte;
    end
  end

  always_comb begin
    frame.at_last      = at_last;
    frame.done         = accept && at_last;
    frame.crc          = crc_next;
    frame.raw          = {kept_bytes[1], kept_bytes[0]};
    frame.cfg          = kept_bytes[2];
    frame.count_remain = kept_bytes[3];
  end

endmodule

`default_nettype wire

/* rtl/core/tsc_result.sv */
// Conversion of a checked frame to degrees and hundredths, with the result register.
`timescale 1ns / 1ps
`default_nettype none

module tsc_result (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire tsc_pkg::frame_t    frame,
  input  wire logic [7:0]         family_code,
  input  wire logic               out_stall,
  output logic                    out_valid,
  output logic                    crc_error,
  output logic signed [7:0]       whole_degrees,
  output logic [6:0]              hundredths
);
  import tsc_pkg::*;

  logic [15:0] word;
  logic [15:0] legacy_word;
  logic [15:0] masked_word;
  logic        bad_crc;

  assign bad_crc     = (frame.crc != 8'd0);
  assign legacy_word = {frame.raw[12:1], 4'b0000}
                       + (LEGACY_COMP_BASE - {8'd0, frame.count_remain});

  always_comb begin
    priority if (frame.cfg[6] && frame.cfg[5]) begin
      masked_word = frame.raw;
    end else if (frame.cfg[6]) begin
      masked_word = {frame.raw[15:1], 1'b0};
    end else if (frame.cfg[5]) begin
      masked_word = {frame.raw[15:2], 2'b00};
    end else begin
      masked_word = {frame.raw[15:3], 3'b000};
    end
  end

  always_comb begin
    if (family_code == FAMILY_LEGACY) begin
      word = legacy_word;
    end else if (family_code == FAMILY_RESMASK) begin
      word = masked_word;
    end else begin
      word = frame.raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (frame.done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame.done) begin
      crc_error     <= bad_crc;
      whole_degrees <= bad_crc ? 8'sd0 : $signed(word[11:4]);
      hundredths    <= bad_crc ? 7'd0 : frac_to_hundredths(word[3:0]);
    end
  end

endmodule

`default_nettype wire

/* rtl/core/temp_scratchpad_check_convert.sv */
// Top level of the one-wire temperature scratchpad check and conversion block.
// Takes the nine scratchpad bytes of a sensor, one request per byte, byte 0 first,
// and after the ninth byte delivers one result: the CRC-8 check flag, whole degrees
// and hundredths. A byte is taken every cycle unless in_stall holds it back. The CRC
// update of the last byte and the conversion of a finished frame lie between the
// frame registers and the result register, so the result is registered in the cycle
// after the last byte. While a result waits under out_stall, bytes of the next frame
// keep being taken, and only that frame's last byte is held back until the waiting
// result has gone. The family code register (reset 40) is read at a frame's last byte.
`timescale 1ns / 1ps
`default_nettype none

module temp_scratchpad_check_convert (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [7:0]         cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         data_byte,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    crc_error,
  output logic signed [7:0]       whole_degrees,
  output logic [6:0]              hundredths
);
  import tsc_pkg::*;

  logic   [7:0] family_code;
  logic         in_accept;
  frame_t       frame;

  always_ff @(posedge clk) begin
    if (rst) begin
      family_code <= FAMILY_RESET;
    end else if (cfg_we) begin
      family_code <= cfg_wdata;
    end
  end

  assign in_stall  = out_valid && out_stall && frame.at_last;
  assign in_accept = in_valid && !in_stall;

  tsc_frame u_frame (
    .clk       (clk),
    .rst       (rst),
    .accept    (in_accept),
    .data_byte (data_byte),
    .frame     (frame)
  );

  tsc_result u_result (
    .clk           (clk),
    .rst           (rst),
    .frame         (frame),
    .family_code   (family_code),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .crc_error     (crc_error),
    .whole_degrees (whole_degrees),
    .hundredths    (hundredths)
  );

  // A new result only ever follows the last byte of a frame.
  a_result_after_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_accept && frame.at_last))
    else $error("result appeared without a completed frame");

  // A failed check carries no temperature.
  a_error_zeroes: assert property (@(posedge clk) disable iff (rst)
    (out_valid && crc_error) |-> (whole_degrees == 8'sd0 && hundredths == 7'd0))
    else $error("nonzero temperature with CRC error");

  a_hundredths_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hundredths <= 7'd94))
    else $error("hundredths out of range");

  // The last byte of a frame never overwrites a result that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !frame.done)
    else $error("waiting result overwritten");

endmodule

`default_nettype wire
